>>> design/cros_pkg.sv
// ---------------------------------------------------------------------------
// cros_pkg
// Shared types and constants for the color region obstacle scorer.
// ---------------------------------------------------------------------------
package cros_pkg;
	localparam int MAX_DIM = 1024;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = $clog2(MAX_DIM);
	localparam int CW = 21;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ROT    = 3'd2;
	localparam logic [2:0] REG_DARK   = 3'd3;
	localparam logic [2:0] REG_ODIV   = 3'd4;
	localparam logic [2:0] REG_GDIV   = 3'd5;
	localparam logic [2:0] REG_WDIV   = 3'd6;

	localparam logic [1:0] STEER_CENTER = 2'd0;
	localparam logic [1:0] STEER_LEFT   = 2'd1;
	localparam logic [1:0] STEER_RIGHT  = 2'd2;

	typedef struct packed {
		logic       last;
		logic       valid_px;
		logic [1:0] col;
		logic       bottom;
		logic       green_zone;
		logic       upper;
		logic       dark;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} cros_px_t;

	typedef struct packed {
		logic       last;
		logic       cnt;
		logic [1:0] col;
		logic       bottom;
		logic       upper;
		logic       dark;
		logic       orange;
		logic       green;
	} cros_ev_t;

	function automatic logic [7:0] clamp8(input logic signed [19:0] x);
		logic signed [19:0] f;
		begin
			f = x >>> 8;
			if (f < 0) clamp8 = 8'd0;
			else if (f > 255) clamp8 = 8'd255;
			else clamp8 = f[7:0];
		end
	endfunction
endpackage

>>> design/cros_div.sv
// ---------------------------------------------------------------------------
// cros_div
// Pipelined restoring divider, one quotient bit per stage, passing a tag.
// ---------------------------------------------------------------------------
module cros_div import cros_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	input  logic [31:0] tag_in,
	output logic [15:0] quo,
	output logic [31:0] tag_out
);
	logic [15:0] n_q [0:16];
	logic [15:0] r_q [0:16];
	logic [15:0] q_q [0:16];
	logic [7:0]  d_q [0:16];
	logic [31:0] t_q [0:16];

	always_comb begin
		n_q[0] = num;
		r_q[0] = '0;
		q_q[0] = '0;
		d_q[0] = den;
		t_q[0] = tag_in;
	end

	for (genvar i = 0; i < 16; i++) begin : g_st
		logic [16:0] rs;
		logic        ge;
		assign rs = {r_q[i], n_q[i][15]};
		assign ge = rs >= {9'd0, d_q[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				t_q[i+1] <= '0;
			end else if (en) begin
				t_q[i+1] <= t_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i+1] <= {n_q[i][14:0], 1'b0};
				r_q[i+1] <= ge ? 16'(rs - {9'd0, d_q[i]}) : rs[15:0];
				q_q[i+1] <= {q_q[i][14:0], ge};
				d_q[i+1] <= d_q[i];
			end
		end
	end

	assign quo = q_q[16];
	assign tag_out = t_q[16];
endmodule

>>> design/cros_front.sv
// ---------------------------------------------------------------------------
// cros_front
// Tracks position, maps rotation, converts to RGB then HSV, classifies.
// ---------------------------------------------------------------------------
module cros_front import cros_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        luma,
	input  logic [7:0]        chroma_u,
	input  logic [7:0]        chroma_v,
	input  logic              frame_last,
	input  logic [DW-1:0]     width_c,
	input  logic [DW-1:0]     height_c,
	input  logic [1:0]        rot,
	input  logic [7:0]        dark_lim,
	input  logic [PW-1:0]     colw,
	input  logic [PW-1:0]     bot,
	input  logic [PW-1:0]     gtop,
	input  logic [PW-1:0]     half,
	output logic              ev_valid,
	output cros_ev_t          ev,
	input  logic              adv
);
	logic [PW-1:0] xs_q, ys_q;
	logic [PW:0]   xn, yn;
	logic          acc;
	logic [PW-1:0] xr, yr;
	logic          inside_f;
	logic          v_s1;
	cros_px_t      px_s1;

	assign in_stall = !adv;
	assign acc = in_valid && adv;
	assign xn = {1'b0, xs_q} + 1'b1;
	assign yn = {1'b0, ys_q} + 1'b1;
	assign inside_f = ({1'b0, xs_q} < width_c) && ({1'b0, ys_q} < height_c);

	always_comb begin
		unique case (rot)
			2'd1: begin xr = PW'(height_c - 1'b1 - ys_q); yr = xs_q; end
			2'd2: begin xr = PW'(width_c - 1'b1 - xs_q); yr = PW'(height_c - 1'b1 - ys_q); end
			2'd3: begin xr = ys_q; yr = PW'(width_c - 1'b1 - xs_q); end
			default: begin xr = xs_q; yr = ys_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xs_q <= '0;
			ys_q <= '0;
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			if (acc) begin
				if (frame_last) begin
					xs_q <= '0;
					ys_q <= '0;
				end else if (xn >= {1'b0, width_c}) begin
					xs_q <= '0;
					ys_q <= (yn >= {1'b0, height_c}) ? '0 : yn[PW-1:0];
				end else begin
					xs_q <= xn[PW-1:0];
				end
			end
		end
	end

	logic signed [19:0] cc, dd, ee;
	assign cc = 20'(signed'({1'b0, luma}) - 20'sd16);
	assign dd = 20'(signed'({1'b0, chroma_u}) - 20'sd128);
	assign ee = 20'(signed'({1'b0, chroma_v}) - 20'sd128);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1.last       <= frame_last;
			px_s1.valid_px   <= inside_f;
			px_s1.col        <= (xr < colw) ? 2'd0 : ((xr < PW'({colw, 1'b0})) ? 2'd1 : 2'd2);
			px_s1.bottom     <= yr >= bot;
			px_s1.green_zone <= yr < gtop;
			px_s1.upper      <= yr < half;
			px_s1.dark       <= luma < dark_lim;
			px_s1.r <= clamp8(20'(298 * cc + 409 * ee + 128));
			px_s1.g <= clamp8(20'(298 * cc - 100 * dd - 208 * ee + 128));
			px_s1.b <= clamp8(20'(298 * cc + 516 * dd + 128));
		end
	end

	// stage 2: max/min and hue numerator
	logic [7:0] mx, mn, dl;
	logic [1:0] sel;
	logic signed [9:0] hd;
	always_comb begin
		mx = px_s1.r; mn = px_s1.r;
		if (px_s1.g > mx) mx = px_s1.g;
		if (px_s1.b > mx) mx = px_s1.b;
		if (px_s1.g < mn) mn = px_s1.g;
		if (px_s1.b < mn) mn = px_s1.b;
		dl = mx - mn;
		if (mx == px_s1.r) begin sel = 2'd0; hd = 10'(signed'({2'b0, px_s1.g}) - signed'({2'b0, px_s1.b})); end
		else if (mx == px_s1.g) begin sel = 2'd1; hd = 10'(signed'({2'b0, px_s1.b}) - signed'({2'b0, px_s1.r})); end
		else begin sel = 2'd2; hd = 10'(signed'({2'b0, px_s1.r}) - signed'({2'b0, px_s1.g})); end
	end

	logic        v_s2;
	logic [15:0] hn_s2, sn_s2;
	logic [7:0]  dl_s2, mx_s2;
	logic        neg_s2;
	logic [1:0]  sel_s2;
	logic [9:0]  cls_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= hd < 0;
			hn_s2  <= 16'(60 * (hd < 0 ? -hd : hd));
			sn_s2  <= 16'(255 * dl);
			dl_s2  <= dl;
			mx_s2  <= mx;
			sel_s2 <= sel;
			cls_s2 <= {px_s1.last, px_s1.valid_px, px_s1.col, px_s1.bottom,
				px_s1.green_zone, px_s1.upper, px_s1.dark, 2'b0};
		end
	end

	logic [15:0] hq, sq;
	logic [31:0] ht, st;
	cros_div u_hdiv (.clk, .arst_n, .en(adv), .num(hn_s2),
		.den(dl_s2 == 8'd0 ? 8'd1 : dl_s2),
		.tag_in({v_s2, dl_s2 == 8'd0, neg_s2, sel_s2, mx_s2, cls_s2, 9'd0}),
		.quo(hq), .tag_out(ht));
	cros_div u_sdiv (.clk, .arst_n, .en(adv), .num(sn_s2),
		.den(mx_s2 == 8'd0 ? 8'd1 : mx_s2), .tag_in('0), .quo(sq), .tag_out(st));

	logic        vo, dz, ng, orange, green;
	logic [1:0]  sl;
	logic [7:0]  mxo;
	logic [9:0]  co;
	logic signed [10:0] hue;
	logic [8:0]  h2;
	logic [7:0]  sat;
	assign {vo, dz, ng, sl, mxo, co} = ht[31:9];
	always_comb begin
		if (dz) hue = '0;
		else unique case (sl)
			2'd0: hue = ng ? 11'(360 - signed'({1'b0, hq[9:0]})) : 11'(hq[9:0]);
			2'd1: hue = ng ? 11'(120 - signed'({1'b0, hq[9:0]})) : 11'(120 + hq[9:0]);
			default: hue = ng ? 11'(240 - signed'({1'b0, hq[9:0]})) : 11'(240 + hq[9:0]);
		endcase
		if (dz && sl == 2'd0) hue = '0;
		h2  = 9'(hue >>> 1);
		sat = (mxo == 8'd0) ? 8'd0 : sq[7:0];
		orange = h2 >= 9'd5 && h2 <= 9'd25 && sat >= 8'd80 && mxo >= 8'd120;
		green  = h2 >= 9'd25 && h2 <= 9'd90 && sat >= 8'd40 && mxo >= 8'd40;
	end

	assign ev_valid  = vo;
	assign ev.last   = co[9];
	assign ev.cnt    = co[8];
	assign ev.col    = co[7:6];
	assign ev.bottom = co[5];
	assign ev.upper  = co[3];
	assign ev.dark   = co[2];
	assign ev.orange = co[5] && orange;
	assign ev.green  = co[5] && co[4] && green;
	logic unused_s;
	assign unused_s = ^{st, sq[15:8], hq[15:10], ht[8:0], co[1:0]};
endmodule

>>> design/cros_queue.sv
// ---------------------------------------------------------------------------
// cros_queue
// Small FIFO of classified pixel events between front and back.
// ---------------------------------------------------------------------------
module cros_queue import cros_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  cros_ev_t wdata,
	input  logic     rd,
	output logic     not_empty,
	output logic     room,
	output cros_ev_t rdata
);
	cros_ev_t   mem_q [0:3];
	logic [2:0] wp_q, rp_q, cnt;
	assign cnt = wp_q - rp_q;
	assign not_empty = cnt != 3'd0;
	assign room = cnt != 3'd4;
	assign rdata = mem_q[rp_q[1:0]];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q[1:0]] <= wdata;
	end
endmodule

>>> design/cros_back.sv
// ---------------------------------------------------------------------------
// cros_back
// Accumulates per-column counts and scores the frame on its last pixel.
// ---------------------------------------------------------------------------
module cros_back import cros_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ev_valid,
	input  cros_ev_t   ev,
	output logic       ev_take,
	input  logic [7:0] odiv,
	input  logic [7:0] gdiv,
	input  logic [7:0] wdiv,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       left_obstacle,
	output logic       center_obstacle,
	output logic       right_obstacle,
	output logic [2:0] left_level,
	output logic [2:0] center_level,
	output logic [2:0] right_level,
	output logic [1:0] steer_direction
);
	logic [CW-1:0] or_q [0:2], gr_q [0:2], bt_q [0:2], dk_q [0:2], ut_q [0:2];
	logic          busy_q;

	assign ev_take = ev_valid && !(out_valid && out_stall) && !busy_q;

	logic [2:0] rk [0:2];
	logic [2:0] blk;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [CW-1:0] bt, ut;
			logic ob, gb, wb;
			bt = (bt_q[i] == '0) ? CW'(1) : bt_q[i];
			ut = (ut_q[i] == '0) ? CW'(1) : ut_q[i];
			ob = (or_q[i] * odiv) >= (CW+8)'(bt);
			gb = (gr_q[i] * gdiv) >= (CW+8)'(bt);
			wb = (dk_q[i] * wdiv) <= (CW+8)'(ut);
			rk[i] = {1'b0, ob, 1'b0} + {1'b0, gb, 1'b0} + {2'b0, wb};
			blk[i] = ob || gb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			left_obstacle <= 1'b0;
			center_obstacle <= 1'b0;
			right_obstacle <= 1'b0;
			left_level <= '0;
			center_level <= '0;
			right_level <= '0;
			steer_direction <= STEER_CENTER;
			for (int i = 0; i < 3; i++) begin
				or_q[i] <= '0; gr_q[i] <= '0; bt_q[i] <= '0; dk_q[i] <= '0; ut_q[i] <= '0;
			end
		end else begin
			if (busy_q && !(out_valid && out_stall)) begin
				busy_q <= 1'b0;
				out_valid <= 1'b1;
				left_level <= rk[0]; center_level <= rk[1]; right_level <= rk[2];
				left_obstacle <= rk[0] >= 3'd2;
				center_obstacle <= rk[1] >= 3'd2;
				right_obstacle <= rk[2] >= 3'd2;
				if ((rk[0] == 0 && rk[1] == 0 && rk[2] == 0) || rk[1] < 3'd2)
					steer_direction <= STEER_CENTER;
				else if (!blk[0] && blk[2]) steer_direction <= STEER_LEFT;
				else if (!blk[2] && blk[0]) steer_direction <= STEER_RIGHT;
				else steer_direction <= (rk[0] <= rk[2]) ? STEER_LEFT : STEER_RIGHT;
				for (int i = 0; i < 3; i++) begin
					or_q[i] <= '0; gr_q[i] <= '0; bt_q[i] <= '0; dk_q[i] <= '0; ut_q[i] <= '0;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (ev_take) begin
				if (ev.cnt) begin
					if (ev.bottom && bt_q[ev.col] != CNT_MAX) bt_q[ev.col] <= bt_q[ev.col] + 1'b1;
					if (ev.orange && or_q[ev.col] != CNT_MAX) or_q[ev.col] <= or_q[ev.col] + 1'b1;
					if (ev.green && gr_q[ev.col] != CNT_MAX) gr_q[ev.col] <= gr_q[ev.col] + 1'b1;
					if (ev.upper && ut_q[ev.col] != CNT_MAX) ut_q[ev.col] <= ut_q[ev.col] + 1'b1;
					if (ev.upper && ev.dark && dk_q[ev.col] != CNT_MAX)
						dk_q[ev.col] <= dk_q[ev.col] + 1'b1;
				end
				if (ev.last) busy_q <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !ev_take)
		else $error("event taken while scoring");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> steer_direction != 2'd3)
		else $error("bad steer code");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy_q))
		else $error("result without frame end");
endmodule

>>> design/color_region_obstacle_scorer.sv
// ---------------------------------------------------------------------------
// color_region_obstacle_scorer
// Per-column color and darkness scoring of a YUV pixel stream.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the four-entry event queue has room. A pixel
// passes the RGB stage, the hue numerator stage and the sixteen-stage hue and
// saturation dividers, enters the queue and is counted when the back end takes
// it; the frame_last pixel sets the scoring state, from which the result is
// registered once no earlier result is stalled. The counting side pauses while
// it scores each frame end and holds while a result is stalled; the queue then
// fills and in_stall rises. Write the registers only while no pixel is in flight.
module color_region_obstacle_scorer import cros_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  luma,
	input  logic [7:0]  chroma_u,
	input  logic [7:0]  chroma_v,
	input  logic        frame_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        left_obstacle,
	output logic        center_obstacle,
	output logic        right_obstacle,
	output logic [2:0]  left_level,
	output logic [2:0]  center_level,
	output logic [2:0]  right_level,
	output logic [1:0]  steer_direction
);
	logic [10:0] fw_q, fh_q;
	logic [1:0]  rot_q;
	logic [7:0]  dk_q, od_q, gd_q, wd_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'd520; fh_q <= 11'd240; rot_q <= 2'd3; dk_q <= 8'd70;
			od_q <= 8'd5; gd_q <= 8'd10; wd_q <= 8'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  fw_q <= cfg_data;
				REG_HEIGHT: fh_q <= cfg_data;
				REG_ROT:    rot_q <= cfg_data[1:0];
				REG_DARK:   dk_q <= cfg_data[7:0];
				REG_ODIV:   od_q <= cfg_data[7:0];
				REG_GDIV:   gd_q <= cfg_data[7:0];
				REG_WDIV:   wd_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic [DW-1:0] wc, hc, pw, ph;
	assign wc = (fw_q < 11'd2) ? DW'(2) : ((fw_q > 11'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(fw_q));
	assign hc = (fh_q < 11'd2) ? DW'(2) : ((fh_q > 11'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(fh_q));
	assign pw = rot_q[0] ? hc : wc;
	assign ph = rot_q[0] ? wc : hc;

	// derived geometry, follows the registers at once
	logic [PW-1:0] colw, bot, gtop, half;
	logic [DW+1:0] b3;
	assign b3   = (DW+2)'(ph) * 2'd3;
	assign colw = PW'(((DW+12)'(pw) * (DW+12)'(1366)) >> 12);
	assign bot  = PW'(b3 >> 2);
	assign gtop = PW'((b3 >> 2) + ((((DW+2)'(ph) - (b3 >> 2)) * 3) >> 2));
	assign half = PW'(ph >> 1);

	logic     adv, ev_valid, q_room, q_ne, take;
	cros_ev_t ev, qd;
	// freeze the whole front while the queue is full
	assign adv = q_room;
	cros_front u_front (.clk, .arst_n, .in_valid, .in_stall, .luma, .chroma_u, .chroma_v,
		.frame_last, .width_c(wc), .height_c(hc), .rot(rot_q), .dark_lim(dk_q),
		.colw(colw), .bot(bot), .gtop(gtop), .half(half),
		.ev_valid, .ev, .adv);
	cros_queue u_q (.clk, .arst_n, .wr(ev_valid && adv), .wdata(ev), .rd(take),
		.not_empty(q_ne), .room(q_room), .rdata(qd));
	cros_back u_back (.clk, .arst_n, .ev_valid(q_ne), .ev(qd), .ev_take(take),
		.odiv(od_q), .gdiv(gd_q), .wdiv(wd_q), .out_valid, .out_stall,
		.left_obstacle, .center_obstacle, .right_obstacle,
		.left_level, .center_level, .right_level, .steer_direction);
endmodule
